FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL file that checks its own behavior.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CHK_SAME(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CHK_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

FILE: hdl/iptf_pkg.sv
// Package for the IPv4 prefix trie filter: transaction structs and codes.
// No dependencies.
package iptf_pkg;

  localparam logic [1:0] ACT_LOOKUP   = 2'd0;
  localparam logic [1:0] ACT_INSERT   = 2'd1;
  localparam logic [1:0] ACT_REMOVE   = 2'd2;
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  localparam logic [1:0] MARK_NONE   = 2'd0;
  localparam logic [1:0] MARK_ACCEPT = 2'd1;
  localparam logic [1:0] MARK_REJECT = 2'd2;

  localparam logic [5:0] ADDR_BITS = 6'd32;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] address;
    logic [5:0]  prefix_len;
    logic        verdict_in;
  } request_t;

  typedef struct packed {
    logic        verdict_out;
    logic [31:0] hit_count;
    logic [12:0] prefix_total;
    logic        pool_full;
  } result_t;

  // Write enables of the node store, one per field memory.
  typedef struct packed {
    logic zero;
    logic one;
    logic mark;
    logic hits;
  } wr_en_t;

endpackage

FILE: hdl/iptf_node_store.sv
// Node store of the prefix trie: child, mark and hit memories plus root registers.
// Depends on iptf_pkg.
module iptf_node_store #(
  parameter int NW = 12
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [NW-1:0]   rd_addr,
  output logic [NW-1:0]   rd_zero,
  output logic [NW-1:0]   rd_one,
  output logic [1:0]      rd_mark,
  output logic [31:0]     rd_hits,
  input  iptf_pkg::wr_en_t wr_en,
  input  logic [NW-1:0]   wr_addr,
  input  logic [NW-1:0]   wr_zero,
  input  logic [NW-1:0]   wr_one,
  input  logic [1:0]      wr_mark,
  input  logic [31:0]     wr_hits
);
  import iptf_pkg::*;

  localparam int DEPTH = 1 << NW;

  logic [NW-1:0] zero_mem [DEPTH];
  logic [NW-1:0] one_mem  [DEPTH];
  logic [1:0]    mark_mem [DEPTH];
  logic [31:0]   hits_mem [DEPTH];

  logic [NW-1:0] zero_q, one_q;
  logic [1:0]    mark_q;
  logic [31:0]   hits_q;
  logic          root_sel;

  // Root lives in flops so reset gives its defaults at once.
  logic [NW-1:0] root_zero, root_one;
  logic [1:0]    root_mark;
  logic [31:0]   root_hits;

  logic wr_root;
  assign wr_root = (wr_addr == '0);

  always_ff @(posedge clk) begin
    if (wr_en.zero) zero_mem[wr_addr] <= wr_zero;
    if (wr_en.one)  one_mem[wr_addr]  <= wr_one;
    if (wr_en.mark) mark_mem[wr_addr] <= wr_mark;
    if (wr_en.hits) hits_mem[wr_addr] <= wr_hits;
    zero_q <= zero_mem[rd_addr];
    one_q  <= one_mem[rd_addr];
    mark_q <= mark_mem[rd_addr];
    hits_q <= hits_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_zero <= '0;
      root_one  <= '0;
      root_mark <= MARK_ACCEPT;
      root_hits <= '0;
      root_sel  <= 1'b1;
    end else begin
      root_sel <= (rd_addr == '0);
      if (wr_root && wr_en.zero) root_zero <= wr_zero;
      if (wr_root && wr_en.one)  root_one  <= wr_one;
      if (wr_root && wr_en.mark) root_mark <= wr_mark;
      if (wr_root && wr_en.hits) root_hits <= wr_hits;
    end
  end

  assign rd_zero = root_sel ? root_zero : zero_q;
  assign rd_one  = root_sel ? root_one  : one_q;
  assign rd_mark = root_sel ? root_mark : mark_q;
  assign rd_hits = root_sel ? root_hits : hits_q;

endmodule

FILE: hdl/iptf_level.sv
// Per-level step of the trie walk: child select and depth limit compare.
// No package dependencies.
module iptf_level #(
  parameter int NW = 12
) (
  input  logic [NW-1:0] zero_child,
  input  logic [NW-1:0] one_child,
  input  logic          addr_bit,
  input  logic [5:0]    depth,
  input  logic [5:0]    limit,
  output logic [NW-1:0] child,
  output logic          advance
);
  assign child   = addr_bit ? one_child : zero_child;
  assign advance = (depth < limit) && (child != '0);
endmodule

FILE: hdl/ipv4_prefix_trie_filter.sv
// Each transaction walks the trie level by level; an insert may then build new nodes.
// Throughput: one transaction at a time; busy stays high from accept to the done strobe.
// The walk rate is set by the node store: one dependent registered read per trie level.
// Reset (synchronous) empties the trie at once: root marked accept, one node in use,
// no clearing pass since nodes are zeroed as they are allocated. Results cannot be stalled.
module ipv4_prefix_trie_filter #(
  parameter int NODES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  iptf_pkg::request_t request,
  output logic               done,
  output iptf_pkg::result_t  result
);
  import iptf_pkg::*;

  `include "assert_macros.svh"

  localparam int NW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam logic [CW-1:0] NODES_C = CW'(NODES);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_HIT   = 4'b0100,
    S_ALLOC = 4'b1000
  } state_t;

  state_t state, state_next;

  // Transaction registers.
  logic [1:0]    act;
  logic [31:0]   addr_sh;
  logic [5:0]    len;
  logic          vin;
  logic [5:0]    depth;
  logic [NW-1:0] node;
  logic [NW-1:0] match;
  logic [1:0]    match_mark;

  logic [CW-1:0] next_free, next_free_next;
  logic [CW-1:0] marked_total, marked_total_next;

  // Store ports.
  logic [NW-1:0] rd_addr, rd_zero, rd_one;
  logic [1:0]    rd_mark;
  logic [31:0]   rd_hits;
  wr_en_t        wr_en;
  logic [NW-1:0] wr_addr, wr_zero, wr_one;
  logic [1:0]    wr_mark;
  logic [31:0]   wr_hits;

  logic [NW-1:0] child;
  logic          advance;
  logic [5:0]    limit;
  logic          known_act;

  logic          finish;
  result_t       res_next;

  logic [NW-1:0] m_node;
  logic [1:0]    m_mark;
  logic [CW-1:0] room, need;
  logic [NW-1:0] fresh;
  logic [1:0]    vin_mark;

  iptf_node_store #(.NW(NW)) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_zero (rd_zero),
    .rd_one  (rd_one),
    .rd_mark (rd_mark),
    .rd_hits (rd_hits),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_zero (wr_zero),
    .wr_one  (wr_one),
    .wr_mark (wr_mark),
    .wr_hits (wr_hits)
  );

  iptf_level #(.NW(NW)) u_level (
    .zero_child (rd_zero),
    .one_child  (rd_one),
    .addr_bit   (addr_sh[31]),
    .depth      (depth),
    .limit      (limit),
    .child      (child),
    .advance    (advance)
  );

  assign busy      = (state != S_IDLE);
  assign known_act = (act == ACT_LOOKUP) || (act == ACT_INSERT) || (act == ACT_REMOVE);
  assign limit     = (act == ACT_LOOKUP) ? ADDR_BITS : len;

  // Deepest marked node seen so far, counting the node in hand.
  assign m_node = (rd_mark != MARK_NONE) ? node : match;
  assign m_mark = (rd_mark != MARK_NONE) ? rd_mark : match_mark;

  assign room     = NODES_C - next_free;
  assign need     = CW'(len - depth);
  assign fresh    = next_free[NW-1:0];
  assign vin_mark = vin ? MARK_REJECT : MARK_ACCEPT;

  always_comb begin
    state_next        = state;
    next_free_next    = next_free;
    marked_total_next = marked_total;
    rd_addr           = '0;
    wr_en             = '0;
    wr_addr           = node;
    wr_zero           = '0;
    wr_one            = '0;
    wr_mark           = MARK_NONE;
    wr_hits           = '0;
    finish            = 1'b0;
    res_next          = '0;

    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_WALK;
      end
      S_WALK: begin
        if (advance && known_act) begin
          rd_addr = child;
        end else begin
          case (act)
            ACT_LOOKUP: begin
              rd_addr    = m_node;
              state_next = S_HIT;
            end
            ACT_INSERT: begin
              if (need > room) begin
                finish = 1'b1;
                res_next.pool_full = 1'b1;
              end else if (need == '0) begin
                wr_en.mark = 1'b1;
                wr_mark    = vin_mark;
                if (rd_mark == MARK_NONE) marked_total_next = marked_total + 1'b1;
                finish = 1'b1;
              end else begin
                // Hang the first new node off the last existing one.
                wr_en.zero = !addr_sh[31];
                wr_en.one  = addr_sh[31];
                wr_zero    = fresh;
                wr_one     = fresh;
                state_next = S_ALLOC;
              end
            end
            ACT_REMOVE: begin
              if (len != '0 && depth == len && rd_mark != MARK_NONE) begin
                wr_en.mark        = 1'b1;
                wr_mark           = MARK_NONE;
                marked_total_next = marked_total - 1'b1;
              end
              finish = 1'b1;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      S_HIT: begin
        wr_en.hits = 1'b1;
        wr_addr    = match;
        wr_hits    = rd_hits + 32'd1;
        res_next.verdict_out = (match_mark == MARK_REJECT);
        res_next.hit_count   = rd_hits + 32'd1;
        finish = 1'b1;
      end
      S_ALLOC: begin
        // Initialize the new node; link on to the next one until the end.
        wr_en          = '{zero: 1'b1, one: 1'b1, mark: 1'b1, hits: 1'b1};
        next_free_next = next_free + 1'b1;
        if (depth < len) begin
          wr_zero = addr_sh[31] ? '0 : NW'(fresh + 1'b1);
          wr_one  = addr_sh[31] ? NW'(fresh + 1'b1) : '0;
        end else begin
          wr_mark           = vin_mark;
          marked_total_next = marked_total + 1'b1;
          finish            = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (finish) begin
      state_next            = S_IDLE;
      res_next.prefix_total = 13'(marked_total_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      next_free    <= CW'(1);
      marked_total <= CW'(1);
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      next_free    <= next_free_next;
      marked_total <= marked_total_next;
      done         <= finish;
    end
  end

  // Payload registers: capture on accept, advance one level per alloc cycle and per walk cycle that descends.
  always_ff @(posedge clk) begin
    if (finish) result <= res_next;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          act        <= request.action;
          addr_sh    <= request.address;
          len        <= (request.prefix_len > ADDR_BITS) ? ADDR_BITS : request.prefix_len;
          vin        <= request.verdict_in;
          depth      <= '0;
          node       <= '0;
          match      <= '0;
          match_mark <= MARK_ACCEPT;
        end
      end
      S_WALK: begin
        match      <= m_node;
        match_mark <= m_mark;
        if ((advance && known_act) || state_next == S_ALLOC) begin
          node    <= (advance && known_act) ? child : fresh;
          depth   <= depth + 6'd1;
          addr_sh <= {addr_sh[30:0], 1'b0};
        end
      end
      S_ALLOC: begin
        node    <= NW'(fresh + 1'b1);
        depth   <= depth + 6'd1;
        addr_sh <= {addr_sh[30:0], 1'b0};
      end
      default: begin
      end
    endcase
  end

  // Checks.
  `CHK_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted transaction not busy")
  `CHK_SAME(a_done_idle, clk, rst, done, !busy, "done strobe while still busy")
  `CHK_SAME(a_full_insert, clk, rst, done && result.pool_full, act == ACT_INSERT,
            "pool full flagged on a non-insert")
  `CHK_SAME(a_total_bound, clk, rst, 1'b1, marked_total <= next_free,
            "more marked prefixes than allocated nodes")

endmodule

FILE: dv/tb_ipv4_prefix_trie_filter.sv
// Self-checking testbench for the IPv4 prefix trie filter: directed table, random traffic, then pool fill.
// Depends on iptf_pkg and the ipv4_prefix_trie_filter RTL; results checked against a trie predictor.
module tb_ipv4_prefix_trie_filter;
  import iptf_pkg::*;

  localparam int NODES = 4096;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 840;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  request_t request;
  logic     done;
  result_t  result;

  ipv4_prefix_trie_filter #(.NODES(NODES)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .done(done), .result(result)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Predictor copy of the trie.
  logic [12:0] trie_zero [NODES];
  logic [12:0] trie_one [NODES];
  logic [1:0]  trie_mark [NODES];
  logic [31:0] trie_hits [NODES];
  int          alloc_next;
  logic [12:0] marked_count;

  result_t pending_results [$];
  int      mismatch_count;
  int      watchdog;
  int      send_idle_pct;

  // Directed row: request plus optional typed-in expectation.
  typedef struct {
    request_t req;
    bit       has_exp;
    result_t  exp;
  } vector_t;
  vector_t directed_rows [$];

  function automatic logic [12:0] child_at(int node, logic bit_val);
    return bit_val ? trie_one[node] : trie_zero[node];
  endfunction

  function automatic result_t predict_filter(request_t req);
    result_t r;
    int node, depth, match, len, walked, fresh;
    logic [12:0] nxt;
    r = '0;
    len = (req.prefix_len > ADDR_BITS) ? 32 : int'(req.prefix_len);
    if (req.action == ACT_LOOKUP) begin
      node = 0;
      match = 0;
      for (depth = 0; depth <= 32; depth++) begin
        if (trie_mark[node] != MARK_NONE) match = node;
        if (depth >= 32) break;
        nxt = child_at(node, req.address[31 - depth]);
        if (nxt == 0) break;
        node = nxt;
      end
      trie_hits[match] = trie_hits[match] + 32'd1;
      r.hit_count = trie_hits[match];
      r.verdict_out = (trie_mark[match] == MARK_REJECT);
    end else if (req.action == ACT_INSERT || req.action == ACT_REMOVE) begin
      node = 0;
      walked = 0;
      while (walked < len) begin
        nxt = child_at(node, req.address[31 - walked]);
        if (nxt == 0) break;
        node = nxt;
        walked++;
      end
      if (req.action == ACT_INSERT) begin
        if (len - walked > NODES - alloc_next) begin
          r.pool_full = 1'b1;
        end else begin
          while (walked < len) begin
            fresh = alloc_next;
            alloc_next++;
            trie_zero[fresh] = '0;
            trie_one[fresh] = '0;
            trie_mark[fresh] = MARK_NONE;
            trie_hits[fresh] = '0;
            if (req.address[31 - walked]) trie_one[node] = 13'(fresh);
            else trie_zero[node] = 13'(fresh);
            node = fresh;
            walked++;
          end
          if (trie_mark[node] == MARK_NONE) marked_count++;
          trie_mark[node] = req.verdict_in ? MARK_REJECT : MARK_ACCEPT;
        end
      end else if (len != 0 && walked == len && trie_mark[node] != MARK_NONE) begin
        trie_mark[node] = MARK_NONE;
        marked_count--;
      end
    end
    r.prefix_total = marked_count;
    return r;
  endfunction

  function automatic request_t make_request(logic [1:0] act, logic [31:0] addr,
                                            logic [5:0] len, logic vin);
    request_t q;
    q.action = act;
    q.address = addr;
    q.prefix_len = len;
    q.verdict_in = vin;
    return q;
  endfunction

  function automatic result_t make_result(logic v, logic [31:0] h, logic [12:0] t, logic f);
    result_t q;
    q.verdict_out = v;
    q.hit_count = h;
    q.prefix_total = t;
    q.pool_full = f;
    return q;
  endfunction

  // Send one transaction; hold start until the block takes it.
  task automatic send_request(request_t req, bit has_exp, result_t exp_fixed);
    result_t predicted;
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    predicted = predict_filter(req);
    pending_results.push_back(has_exp ? exp_fixed : predicted);
  endtask

  // Drop start once the last transaction of a burst is taken.
  task automatic stop_sending();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Check every strobed result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", result);
      end else begin
        result_t want;
        want = pending_results.pop_front();
        if (result.verdict_out !== want.verdict_out || result.hit_count !== want.hit_count ||
            result.prefix_total !== want.prefix_total || result.pool_full !== want.pool_full) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p actual %p", want, result);
        end
      end
    end
  end

  // Count cycles with no transaction accepted either way.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Pick a random request, mostly lookups, with the low 24 address bits usually narrowed to a small set.
  function automatic request_t random_request();
    logic [31:0] addr;
    int sel;
    addr = $urandom();
    if ($urandom_range(3, 0) != 0)
      addr[23:0] = {2'($urandom_range(3, 0)), 22'h0} | (addr[23:0] & 24'h3);
    sel = $urandom_range(99, 0);
    return make_request(sel < 55 ? ACT_LOOKUP : sel < 80 ? ACT_INSERT :
                        sel < 97 ? ACT_REMOVE : ACT_RESERVED,
                        addr, 6'($urandom_range(sel < 99 ? 34 : 63, 0)), 1'($urandom()));
  endfunction

  initial begin
    result_t none;
    int phase;
    none = '0;
    mismatch_count = 0;
    watchdog = 0;
    send_idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    for (int i = 0; i < NODES; i++) begin
      trie_zero[i] = '0; trie_one[i] = '0; trie_mark[i] = MARK_NONE; trie_hits[i] = '0;
    end
    trie_mark[0] = MARK_ACCEPT;
    alloc_next = 1;
    marked_count = 1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed table: reset state, extremes, every action and special case.
    directed_rows = '{
      '{make_request(ACT_LOOKUP, 32'h0, 6'd0, 1'b0), 1'b1,
        make_result(1'b0, 32'd1, 13'd1, 1'b0)},
      '{make_request(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd32, 1'b1), 1'b1,
        make_result(1'b0, 32'd2, 13'd1, 1'b0)},
      '{make_request(ACT_INSERT, 32'h0, 6'd0, 1'b1), 1'b1,
        make_result(1'b0, 32'd0, 13'd1, 1'b0)},
      '{make_request(ACT_LOOKUP, 32'h1234_5678, 6'd0, 1'b0), 1'b1,
        make_result(1'b1, 32'd3, 13'd1, 1'b0)},
      '{make_request(ACT_REMOVE, 32'h0, 6'd0, 1'b0), 1'b1,
        make_result(1'b0, 32'd0, 13'd1, 1'b0)},
      '{make_request(ACT_INSERT, 32'h0A00_0000, 6'd8, 1'b0), 1'b1,
        make_result(1'b0, 32'd0, 13'd2, 1'b0)},
      '{make_request(ACT_LOOKUP, 32'h0A01_0203, 6'd0, 1'b0), 1'b0, none},
      '{make_request(ACT_INSERT, 32'h0A0B_0000, 6'd16, 1'b1), 1'b0, none},
      '{make_request(ACT_LOOKUP, 32'h0A0B_FFFF, 6'd0, 1'b0), 1'b0, none},
      '{make_request(ACT_INSERT, 32'h0A00_0000, 6'd8, 1'b1), 1'b0, none},
      '{make_request(ACT_LOOKUP, 32'h0A01_0203, 6'd0, 1'b0), 1'b0, none},
      '{make_request(ACT_INSERT, 32'hFFFF_FFFF, 6'd63, 1'b0), 1'b0, none},
      '{make_request(ACT_LOOKUP, 32'hFFFF_FFFF, 6'd0, 1'b0), 1'b0, none},
      '{make_request(ACT_REMOVE, 32'hC0A8_0000, 6'd16, 1'b0), 1'b0, none},
      '{make_request(ACT_REMOVE, 32'h0A0B_0000, 6'd20, 1'b0), 1'b0, none},
      '{make_request(ACT_REMOVE, 32'h0A0B_0000, 6'd16, 1'b0), 1'b0, none},
      '{make_request(ACT_REMOVE, 32'hFFFF_FFFF, 6'd33, 1'b0), 1'b0, none},
      '{make_request(ACT_RESERVED, 32'hFFFF_FFFF, 6'd63, 1'b1), 1'b0, none},
      '{make_request(ACT_LOOKUP, 32'h0A0B_0001, 6'd0, 1'b0), 1'b0, none},
      '{make_request(ACT_INSERT, 32'h5555_5555, 6'd32, 1'b1), 1'b0, none},
      '{make_request(ACT_LOOKUP, 32'h5555_5555, 6'd0, 1'b0), 1'b0, none}
    };
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].has_exp, directed_rows[i].exp);
    stop_sending();

    // Hold off until the block has drained every expected transaction.
    while (pending_results.size() != 0) @(negedge clk);

    // Random traffic in three idling phases.
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 68 : 0;
      for (int n = 0; n < RANDOM_ITEMS / 3; n++)
        send_request(random_request(), 1'b0, none);
    end

    // Fill the pool with deep random paths until an insert is refused.
    while (alloc_next < NODES - 40)
      send_request(make_request(ACT_INSERT, $urandom(), 6'd32, 1'($urandom())), 1'b0, none);
    repeat (4) send_request(make_request(ACT_INSERT, $urandom(), 6'd32, 1'b1), 1'b0, none);
    repeat (20) send_request(random_request(), 1'b0, none);
    stop_sending();

    while (pending_results.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
